// ===== hw/rtl/wca_pkg.sv =====
// Package: shared constants, types and the reciprocal table of the co-occurrence accumulator.
package wca_pkg;

    localparam int MAX_WINDOW   = 16;
    localparam int VOCAB_DEPTH  = 65536;
    localparam int DENSE_DEPTH  = 262144;
    localparam int HIST_AW      = $clog2(MAX_WINDOW);
    localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
    localparam int VOCAB_AW     = $clog2(VOCAB_DEPTH);
    localparam int DENSE_AW     = $clog2(DENSE_DEPTH);
    localparam int OFFSET_W     = 19;
    localparam int CELL_W       = 32;
    localparam int WEIGHT_W     = 17;
    localparam int ID_W         = 16;

    localparam logic [31:0] PRODUCT_LIMIT_RESET = 32'd25000000;
    localparam logic [4:0]  WINDOW_SIZE_RESET   = 5'd15;

    localparam logic [0:0] REG_PRODUCT_LIMIT = 1'b0;
    localparam logic [0:0] REG_WINDOW_SIZE   = 1'b1;

    localparam logic [1:0] OP_WORD   = 2'd0;
    localparam logic [1:0] OP_OFFSET = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic KIND_PAIR = 1'b0;
    localparam logic KIND_CELL = 1'b1;

    // Q1.16 weight for distance d, rounded to nearest; d of zero never used.
    function automatic logic [WEIGHT_W-1:0] recip_q16(input logic [CNT_W-1:0] d);
        logic [WEIGHT_W-1:0] r;
        begin
            case (d)
                5'd1:  r = 17'd65536;
                5'd2:  r = 17'd32768;
                5'd3:  r = 17'd21845;
                5'd4:  r = 17'd16384;
                5'd5:  r = 17'd13107;
                5'd6:  r = 17'd10923;
                5'd7:  r = 17'd9362;
                5'd8:  r = 17'd8192;
                5'd9:  r = 17'd7282;
                5'd10: r = 17'd6554;
                5'd11: r = 17'd5958;
                5'd12: r = 17'd5461;
                5'd13: r = 17'd5041;
                5'd14: r = 17'd4681;
                5'd15: r = 17'd4369;
                5'd16: r = 17'd4096;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_INIT   = 8'b0000_0010,
        ST_OFFRD  = 8'b0000_0100,
        ST_PAIR   = 8'b0000_1000,
        ST_RMW    = 8'b0001_0000,
        ST_RDCELL = 8'b0010_0000,
        ST_EMIT   = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

endpackage

// ===== hw/rtl/wca_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module wca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/window_cooccurrence_accumulator_unit.sv =====
// Top level: windowed co-occurrence accumulator with dense table and pair stream.
//
// Usage:
//   s_axis: one transfer per command. tdata packs op, word_id, known,
//   end_of_line, cell_address, offset_value. Op 0 is a word event, op 1
//   loads the dense row offset of word_id, op 2 reads and clears one cell.
//   m_axis: one transfer per result: kind, centre_id, context_id, weight,
//   cell_value in tdata, last in tlast.
//   The controller takes one command at a time.
//   A word event walks the history oldest first; a dense entry takes a
//   dense read in ST_PAIR, then a write back in ST_RMW, any other entry
//   is handled in ST_PAIR alone, and an emitted pair waits for the
//   output register to be free. Op 1 writes the offset table on the
//   transfer itself; op 2 passes through ST_RDCELL, then ST_EMIT, where
//   its result is registered once the output register is free.
//   Reset: history and registers return to their reset values, then a
//   clearing pass writes zero to every dense cell (DENSE_DEPTH, 262144),
//   during which s_axis_tready stays low.
//   Stall: when m_axis_tready is low the result holds and a pair to emit waits.
module window_cooccurrence_accumulator_unit
    import wca_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: op[1:0], word_id[17:2], known[18], end_of_line[19],
    // cell_address[37:20], offset_value[56:38], zero fill to 64
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: kind[0], centre_id[16:1], context_id[32:17], weight[49:33],
    // cell_value[81:50], zero fill to 88
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    // configuration
    logic [31:0] product_limit_reg;
    logic [4:0]  window_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            product_limit_reg <= PRODUCT_LIMIT_RESET;
            window_size_reg   <= WINDOW_SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PRODUCT_LIMIT: product_limit_reg <= cfg_wdata;
                REG_WINDOW_SIZE:   window_size_reg   <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] eff_window;
    always_comb begin
        if (window_size_reg == '0) begin
            eff_window = CNT_W'(1);
        end else if (window_size_reg > 5'(MAX_WINDOW)) begin
            eff_window = CNT_W'(MAX_WINDOW);
        end else begin
            eff_window = CNT_W'(window_size_reg);
        end
    end

    // input fields
    logic [1:0]          in_op;
    logic [ID_W-1:0]     in_word;
    logic                in_known;
    logic                in_eol;
    logic [17:0]         in_addr;
    logic [OFFSET_W-1:0] in_offv;
    assign in_op    = s_axis_tdata[1:0];
    assign in_word  = s_axis_tdata[17:2];
    assign in_known = s_axis_tdata[18];
    assign in_eol   = s_axis_tdata[19];
    assign in_addr  = s_axis_tdata[37:20];
    assign in_offv  = s_axis_tdata[56:38];

    // history: a circular buffer, entry 0 oldest at head_reg
    logic [ID_W-1:0]    hist_id_reg   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] hist_kn_reg;
    logic [HIST_AW-1:0] head_reg;
    logic [CNT_W-1:0]   count_reg;

    state_t state_reg, state_next;

    // latched command
    logic [ID_W-1:0]  word_reg;
    logic             kn_reg;
    logic             eol_reg;
    logic [17:0]      addr_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [OFFSET_W-1:0] row_reg;
    logic             row_ok_reg;
    logic [DENSE_AW:0] clr_reg;

    // pending pair held before emitting so last can be decided
    logic             pend_reg;
    logic [ID_W-1:0]  pend_ctx_reg;
    logic [WEIGHT_W-1:0] pend_w_reg;

    // output register
    logic        ovalid_reg;
    logic [87:0] odata_reg;
    logic        olast_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;
    logic out_free;
    assign out_free = !ovalid_reg || m_axis_tready;

    // rams
    logic                 off_we;
    logic [VOCAB_AW-1:0]  off_raddr;
    logic [OFFSET_W-1:0]  off_rdata;
    logic                 den_we;
    logic [DENSE_AW-1:0]  den_waddr, den_raddr;
    logic [CELL_W-1:0]    den_wdata, den_rdata;

    wca_ram #(.WIDTH(OFFSET_W), .DEPTH(VOCAB_DEPTH)) u_offsets (
        .aclk(aclk), .we(off_we), .waddr(in_word[VOCAB_AW-1:0]), .wdata(in_offv),
        .raddr(off_raddr), .rdata(off_rdata)
    );
    wca_ram #(.WIDTH(CELL_W), .DEPTH(DENSE_DEPTH)) u_dense (
        .aclk(aclk), .we(den_we), .waddr(den_waddr), .wdata(den_wdata),
        .raddr(den_raddr), .rdata(den_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    assign off_we    = acc && (in_op == OP_OFFSET);
    assign off_raddr = in_word[VOCAB_AW-1:0];

    // current history entry
    logic [HIST_AW-1:0] slot;
    logic [ID_W-1:0]    cur_ctx;
    logic               cur_kn;
    logic [WEIGHT_W-1:0] cur_w;
    logic [33:0]        prod;
    logic               is_dense;
    logic [OFFSET_W:0]  cell_addr;
    logic               cell_ok;
    assign slot    = head_reg + idx_reg[HIST_AW-1:0];
    assign cur_ctx = hist_id_reg[slot];
    assign cur_kn  = hist_kn_reg[slot];
    assign cur_w   = recip_q16(count_reg - idx_reg);
    // narrow product: 17x17 bits
    assign prod     = 34'({1'b0, word_reg} + 17'd1) * 34'({1'b0, cur_ctx} + 17'd1);
    assign is_dense = prod <= {2'b0, product_limit_reg};
    assign cell_addr = {1'b0, row_reg} + (OFFSET_W+1)'(cur_ctx);
    assign cell_ok  = row_ok_reg && (cell_addr < (OFFSET_W+1)'(DENSE_DEPTH));

    // read address of op 2 inside the table
    logic addr_ok;
    assign addr_ok = {1'b0, addr_reg} < 19'(DENSE_DEPTH);

    logic [DENSE_AW-1:0] rmw_addr_reg;
    logic [WEIGHT_W-1:0] rmw_w_reg;
    logic [CELL_W:0]     sum;
    assign sum = {1'b0, den_rdata} + (CELL_W+1)'(rmw_w_reg);

    always_comb begin
        den_we    = 1'b0;
        den_waddr = rmw_addr_reg;
        den_wdata = '0;
        den_raddr = addr_reg[DENSE_AW-1:0];
        if (state_reg == ST_INIT) begin
            den_we    = 1'b1;
            den_waddr = clr_reg[DENSE_AW-1:0];
        end else if (state_reg == ST_RMW) begin
            den_we    = 1'b1;
            den_wdata = sum[CELL_W] ? '1 : sum[CELL_W-1:0];
        end else if (state_reg == ST_EMIT) begin
            // clear the cell on the edge that takes its value out
            den_we    = out_free && addr_ok;
            den_waddr = addr_reg[DENSE_AW-1:0];
        end
        if (state_reg == ST_PAIR) begin
            den_raddr = cell_addr[DENSE_AW-1:0];
        end
    end

    logic walk_end;
    assign walk_end = (idx_reg == count_reg) || !kn_reg;

    // output register loads a new result this cycle
    logic out_load;
    assign out_load = out_free &&
        (((state_reg == ST_PAIR) && !walk_end && cur_kn && !is_dense && pend_reg) ||
         (state_reg == ST_EMIT) ||
         ((state_reg == ST_DONE) && pend_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            clr_reg     <= '0;
            ovalid_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            head_reg    <= '0;
            hist_kn_reg <= '0;
        end else begin
            if (out_load) begin
                ovalid_reg <= 1'b1;
            end else if (ovalid_reg && m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (DENSE_AW+1)'(DENSE_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (acc) begin
                        word_reg <= in_word;
                        kn_reg   <= in_known;
                        eol_reg  <= in_eol;
                        addr_reg <= in_addr;
                        idx_reg  <= '0;
                        case (in_op)
                            OP_WORD: state_reg <= ST_OFFRD;
                            OP_READ: state_reg <= ST_RDCELL;
                            default: ;
                        endcase
                    end
                end
                ST_OFFRD: begin
                    row_reg    <= off_rdata;
                    row_ok_reg <= 32'(word_reg) < VOCAB_DEPTH;
                    state_reg  <= ST_PAIR;
                end
                ST_PAIR: begin
                    if (walk_end) begin
                        state_reg <= ST_DONE;
                    end else if (!cur_kn) begin
                        idx_reg <= idx_reg + 1'b1;
                    end else if (is_dense) begin
                        idx_reg <= idx_reg + 1'b1;
                        if (cell_ok) begin
                            rmw_addr_reg <= cell_addr[DENSE_AW-1:0];
                            rmw_w_reg    <= cur_w;
                            state_reg    <= ST_RMW;
                        end
                    end else if (!pend_reg || out_free) begin
                        // hand the held pair to the output, hold the new one
                        if (pend_reg) begin
                            olast_reg  <= 1'b0;
                            odata_reg  <= {6'b0, 32'b0, pend_w_reg, pend_ctx_reg,
                                           word_reg, KIND_PAIR};
                        end
                        pend_reg     <= 1'b1;
                        pend_ctx_reg <= cur_ctx;
                        pend_w_reg   <= cur_w;
                        idx_reg      <= idx_reg + 1'b1;
                    end
                end
                ST_RMW: begin
                    state_reg <= ST_PAIR;
                end
                ST_RDCELL: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        olast_reg  <= 1'b1;
                        odata_reg  <= {6'b0,
                                       addr_ok ? den_rdata : 32'b0,
                                       17'b0, 16'b0, 16'b0, KIND_CELL};
                        state_reg  <= ST_IDLE;
                    end
                end
                ST_DONE: begin
                    if (!pend_reg || out_free) begin
                        if (pend_reg) begin
                            olast_reg  <= 1'b1;
                            odata_reg  <= {6'b0, 32'b0, pend_w_reg, pend_ctx_reg,
                                           word_reg, KIND_PAIR};
                        end
                        pend_reg <= 1'b0;
                        // update history
                        if (eol_reg) begin
                            count_reg   <= '0;
                            head_reg    <= '0;
                            hist_kn_reg <= '0;
                        end else if (count_reg >= eff_window) begin
                            // drop oldest entries until new word fits
                            head_reg <= head_reg + HIST_AW'(count_reg - eff_window + 1'b1);
                            count_reg <= eff_window;
                            hist_id_reg[HIST_AW'(head_reg + count_reg)] <=
                                kn_reg ? word_reg : '0;
                            hist_kn_reg[HIST_AW'(head_reg + count_reg)] <= kn_reg;
                        end else begin
                            count_reg <= count_reg + 1'b1;
                            hist_id_reg[HIST_AW'(head_reg + count_reg)] <=
                                kn_reg ? word_reg : '0;
                            hist_kn_reg[HIST_AW'(head_reg + count_reg)] <= kn_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // history never exceeds the largest window
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_WINDOW))
        else $error("history count out of range");

    // no input accepted while the dense table is being cleared
    a_no_accept_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT) |-> !s_axis_tready)
        else $error("ready during clearing pass");

    // a held result stays until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output changed while stalled");

    // a read-modify-write always returns to the walk
    a_rmw_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RMW) |=> (state_reg == ST_PAIR))
        else $error("rmw did not return to walk");

endmodule
